// ===== hw/rtl/descending_sort_engine_macros.svh =====
// ----------------------------------------------------------------------------
// descending sort engine assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef DESCENDING_SORT_ENGINE_MACROS_SVH
`define DESCENDING_SORT_ENGINE_MACROS_SVH

// same-cycle implication
`define DSE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("descending sort engine: same-cycle check failed");

// next-cycle implication
`define DSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("descending sort engine: next-cycle check failed");

`endif

// ===== hw/rtl/dse_pkg.sv =====
// ----------------------------------------------------------------------------
// dse_pkg
// shared types and constants of the descending sort engine
// ----------------------------------------------------------------------------
package dse_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int VALUE_W      = 32;
   localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);

   typedef struct packed {
      logic load;
      logic shift;
   } dse_ctl_type;

   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
   } dse_slot_type;

endpackage

// ===== hw/rtl/dse_cell.sv =====
// ----------------------------------------------------------------------------
// dse_cell
// one slot of the insertion chain: keeps the larger value, hands its old
// value down on insert and takes its lower neighbor's value on drain
// ----------------------------------------------------------------------------
module dse_cell
   import dse_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  dse_ctl_type               ctl,
   input  logic signed [VALUE_W-1:0] new_value,
   input  dse_slot_type              prev_slot,
   input  logic                      prev_gt,
   input  dse_slot_type              next_slot,
   output dse_slot_type              slot,
   output logic                      gt
);

   logic                      valid_ff, valid_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;

   // empty slots count as below every value
   assign gt = !valid_ff || (new_value > value_ff);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctl.shift) begin
         valid_in = next_slot.valid;
         value_in = next_slot.value;
      end else if (ctl.load && gt) begin
         if (prev_gt) begin
            valid_in = prev_slot.valid;
            value_in = prev_slot.value;
         end else begin
            valid_in = 1'b1;
            value_in = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign slot.valid = valid_ff;
   assign slot.value = value_ff;

endmodule

// ===== hw/rtl/descending_sort_engine.sv =====
// The first result is offered in the cycle after the item marked last.
// Throughput: one item per cycle while loading, one result per cycle while
// draining with rsp_ready high; no new item is taken until the final
// result of a set is taken. The cell chain holds the set sorted at all times.
// Reset: synchronous, active high; clears the chain, count and flags at once.
// ----------------------------------------------------------------------------
// descending_sort_engine
// systolic insertion sorter returning each set largest first
// ----------------------------------------------------------------------------
module descending_sort_engine
   import dse_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_value_res,
   output logic                      rsp_final_res,
   output logic                      rsp_overflow
);

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               dropped_ff, dropped_in;

   dse_ctl_type        ctl;
   dse_slot_type       slot_w [MAX_ELEMENTS];
   logic               gt_w   [MAX_ELEMENTS];

   logic req_take, rsp_take, has_room;

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_DRAIN);
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ready;
   assign has_room  = count_ff < COUNT_W'(MAX_ELEMENTS);

   assign ctl.load  = req_take && has_room;
   assign ctl.shift = rsp_take;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_cell
         dse_slot_type prev_slot, next_slot;
         logic         prev_gt;
         if (gi == 0) begin : g_head
            assign prev_slot = '0;
            assign prev_gt   = 1'b0;
         end else begin : g_body
            assign prev_slot = slot_w[gi-1];
            assign prev_gt   = gt_w[gi-1];
         end
         if (gi == MAX_ELEMENTS - 1) begin : g_tail
            assign next_slot = '0;
         end else begin : g_link
            assign next_slot = slot_w[gi+1];
         end
         dse_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .new_value (req_value),
            .prev_slot (prev_slot),
            .prev_gt   (prev_gt),
            .next_slot (next_slot),
            .slot      (slot_w[gi]),
            .gt        (gt_w[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (has_room) begin
                  count_in = count_ff + COUNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_take && rsp_final_res) begin
               state_in   = ST_LOAD;
               count_in   = '0;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   assign rsp_value_res = slot_w[0].value;
   assign rsp_final_res = !slot_w[1].valid;
   assign rsp_overflow  = dropped_ff;

endmodule

// ===== hw/rtl/dse_checker.sv =====
// ----------------------------------------------------------------------------
// dse_checker
// port-level checks of the descending sort engine, bound to the top level
// ----------------------------------------------------------------------------
`include "descending_sort_engine_macros.svh"

module dse_checker
   import dse_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_last,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [VALUE_W-1:0] rsp_value_res,
   input logic                      rsp_final_res,
   input logic                      rsp_overflow
);

   logic               rsp_take, rsp_take_more, req_close, rsp_stall;
   logic [VALUE_W+1:0] rsp_word;

   assign rsp_take      = rsp_valid && rsp_ready;
   assign rsp_take_more = rsp_take && !rsp_final_res;
   assign req_close     = req_valid && req_ready && req_last;
   assign rsp_stall     = rsp_valid && !rsp_ready;
   assign rsp_word      = {rsp_value_res, rsp_final_res, rsp_overflow};

   // a stalled item holds
   `DSE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

   // no item taken while a set drains
   `DSE_ASSERT_NOW(a_no_load_in_drain, clock, reset, rsp_valid, !req_ready)

   // closing item starts the drain
   `DSE_ASSERT_NEXT(a_close_drains, clock, reset, req_close, rsp_valid)

   // drain runs without gaps, overflow fixed for the set
   `DSE_ASSERT_NEXT(a_drain_flags, clock, reset, rsp_take_more, rsp_valid && $stable(rsp_overflow))

   // order descending
   `DSE_ASSERT_NEXT(a_desc, clock, reset, rsp_take_more, rsp_value_res <= $past(rsp_value_res))

endmodule

bind descending_sort_engine dse_checker u_dse_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_last      (req_last),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_value_res (rsp_value_res),
   .rsp_final_res (rsp_final_res),
   .rsp_overflow  (rsp_overflow)
);
